>>> rtl/vrd_pkg.sv
// Shared types and constants for the VVC RTP depacketiser.
// Used by the front end, the command queue, the back end and the top level.
package vrd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FU_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATE_EN = 1'd1;

    localparam logic [4:0] FU_TYPE_RESET = 5'd29;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_GAP  = 2'd1,
        ST_LATE = 2'd2,
        ST_MALF = 2'd3
    } t_status;

    // One request from the front end: the results one payload byte causes.
    typedef struct packed {
        logic       abort;
        t_status    status;
        logic       start;
        logic [7:0] hdr0;
        logic       data_en;
        logic [7:0] data;
        logic       data_end;
        logic       end_mark;
    } t_cmd;

endpackage

>>> rtl/vrd_front.sv
// Front end of the VVC RTP depacketiser: packet parsing, sequence checks and
// configuration registers. Emits at most one request per payload byte. Uses vrd_pkg.
module vrd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    input  logic                          i_first,
    input  logic                          i_last,
    input  logic [15:0]                   i_seq,
    input  logic                          i_cfg_we,
    input  logic [vrd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_push,
    output vrd_pkg::t_cmd                 o_cmd
);
    import vrd_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_FRAG   = 2'd2,
        MODE_DROP   = 2'd3
    } t_mode;

    logic [4:0]  r_fu_type;
    logic        r_late_en;
    logic [15:0] r_last_seq, n_last_seq;
    logic        r_seq_seen, n_seq_seen;
    logic [1:0]  r_byte_pos, n_byte_pos;
    logic [7:0]  r_hdr0, n_hdr0;
    logic [2:0]  r_tid, n_tid;
    t_mode       r_mode, n_mode;
    logic        r_nal_open, n_nal_open;
    logic        r_eou, n_eou;

    logic [15:0] diff;
    logic        late;
    logic        gap;
    logic        fu_s;
    logic        fu_e;
    t_cmd        cmd;

    assign diff = i_seq - r_last_seq;
    assign late = r_seq_seen && r_late_en && diff[15];
    assign gap  = r_seq_seen && (diff >= 16'd2) && !diff[15];
    assign fu_s = i_byte[7];
    assign fu_e = i_byte[6];

    always_comb begin
        n_last_seq = r_last_seq;
        n_seq_seen = r_seq_seen;
        n_byte_pos = r_byte_pos;
        n_hdr0     = r_hdr0;
        n_tid      = r_tid;
        n_mode     = r_mode;
        n_nal_open = r_nal_open;
        n_eou      = r_eou;
        cmd        = '0;
        cmd.status = ST_OK;
        cmd.hdr0   = r_hdr0;
        cmd.data   = i_byte;

        if (i_first) begin
            if ((r_mode == MODE_SINGLE && r_byte_pos >= 2'd2) ||
                (r_mode == MODE_FRAG && r_nal_open)) begin
                cmd.abort  = 1'b1;
                n_nal_open = 1'b0;
            end
            n_mode     = MODE_IDLE;
            n_byte_pos = 2'd0;
            n_eou      = 1'b0;
            if (late) begin
                cmd.status = ST_LATE;
                n_mode     = i_last ? MODE_IDLE : MODE_DROP;
            end else begin
                n_last_seq = i_seq;
                n_seq_seen = 1'b1;
                if (i_byte[7:6] != 2'b00 || i_last) begin
                    cmd.status = ST_MALF;
                    n_mode     = i_last ? MODE_IDLE : MODE_DROP;
                end else begin
                    if (gap) begin
                        cmd.status = ST_GAP;
                    end
                    n_hdr0     = i_byte;
                    n_mode     = MODE_SINGLE;
                    n_byte_pos = 2'd1;
                end
            end
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                end
                MODE_DROP: begin
                    if (i_last) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_SINGLE: begin
                    if (r_byte_pos <= 2'd1) begin
                        n_tid = i_byte[2:0];
                        if (i_byte[7:3] == r_fu_type) begin
                            if (i_last) begin
                                cmd.status = ST_MALF;
                                n_mode     = MODE_IDLE;
                            end else begin
                                n_mode     = MODE_FRAG;
                                n_byte_pos = 2'd2;
                            end
                        end else begin
                            cmd.abort     = r_nal_open;
                            n_nal_open    = 1'b0;
                            cmd.start     = 1'b1;
                            cmd.data_en   = 1'b1;
                            cmd.data_end  = i_last;
                            n_byte_pos    = 2'd2;
                            if (i_last) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                    end else begin
                        cmd.data_en  = 1'b1;
                        cmd.data_end = i_last;
                        if (i_last) begin
                            n_mode = MODE_IDLE;
                        end
                        if (r_byte_pos != 2'd3) begin
                            n_byte_pos = r_byte_pos + 2'd1;
                        end
                    end
                end
                MODE_FRAG: begin
                    if (r_byte_pos <= 2'd2) begin
                        if (!fu_s && !r_nal_open) begin
                            cmd.status = ST_MALF;
                            n_mode     = i_last ? MODE_IDLE : MODE_DROP;
                        end else begin
                            if (fu_s) begin
                                cmd.abort    = r_nal_open;
                                cmd.start    = 1'b1;
                                cmd.data_en  = 1'b1;
                                cmd.data     = {i_byte[4:0], r_tid};
                                cmd.data_end = fu_e && i_last;
                                n_nal_open   = !(fu_e && i_last);
                            end else if (fu_e && i_last) begin
                                cmd.end_mark = 1'b1;
                                n_nal_open   = 1'b0;
                            end
                            n_eou      = fu_e;
                            n_byte_pos = 2'd3;
                            if (i_last) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                    end else begin
                        if (r_nal_open) begin
                            cmd.data_en  = 1'b1;
                            cmd.data_end = i_last && r_eou;
                            if (i_last && r_eou) begin
                                n_nal_open = 1'b0;
                            end
                        end
                        if (i_last) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (cmd.abort || (cmd.status != ST_OK) || cmd.start ||
                                 cmd.data_en || cmd.end_mark);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fu_type  <= FU_TYPE_RESET;
            r_late_en  <= 1'b1;
            r_last_seq <= '0;
            r_seq_seen <= 1'b0;
            r_byte_pos <= '0;
            r_hdr0     <= '0;
            r_tid      <= '0;
            r_mode     <= MODE_IDLE;
            r_nal_open <= 1'b0;
            r_eou      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FU_TYPE: r_fu_type <= i_cfg_data[4:0];
                    CFG_LATE_EN: r_late_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_last_seq <= n_last_seq;
                r_seq_seen <= n_seq_seen;
                r_byte_pos <= n_byte_pos;
                r_hdr0     <= n_hdr0;
                r_tid      <= n_tid;
                r_mode     <= n_mode;
                r_nal_open <= n_nal_open;
                r_eou      <= n_eou;
            end
        end
    end

endmodule

>>> rtl/vrd_cmd_fifo.sv
// Request queue between the front and back ends of the VVC RTP depacketiser.
// Register-based FIFO of vrd_pkg::t_cmd entries.
module vrd_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vrd_pkg::t_cmd i_data,
    output logic          o_ready,
    output logic          o_valid,
    output vrd_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import vrd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("request queue count beyond depth");

endmodule

>>> rtl/vrd_back.sv
// Back end of the VVC RTP depacketiser: expands queued requests into result
// items, one per cycle while the output is not stalled, through a registered output stage. Uses vrd_pkg.
module vrd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  vrd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_byte_valid,
    output logic          o_nal_begin,
    output logic          o_nal_end,
    output logic          o_nal_abort,
    output logic [1:0]    o_status
);
    import vrd_pkg::*;

    t_cmd       r_cmd;
    logic [7:0] r_mask, n_mask;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_byte_valid;
    logic       r_begin;
    logic       r_end;
    logic       r_abort;
    logic [1:0] r_status;

    logic [7:0] sel;
    logic [7:0] rem;
    logic [7:0] new_mask;
    logic       avail;
    logic       adv;
    logic       load;
    logic [7:0] s_byte;

    assign new_mask = {i_cmd.end_mark, i_cmd.data_en, {4{i_cmd.start}},
                       i_cmd.status != ST_OK, i_cmd.abort};
    assign avail    = |r_mask;
    assign sel      = r_mask & (~r_mask + 8'd1);
    assign rem      = r_mask & (r_mask - 8'd1);
    assign adv      = avail && (!r_valid || i_ready);
    assign load     = !avail || (adv && rem == '0);
    assign o_cmd_pop = load && i_cmd_valid;
    assign n_mask   = o_cmd_pop ? new_mask : (adv ? rem : r_mask);

    always_comb begin
        s_byte = '0;
        if (sel[4]) begin
            s_byte = 8'h01;
        end else if (sel[5]) begin
            s_byte = r_cmd.hdr0;
        end else if (sel[6]) begin
            s_byte = r_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_byte       <= s_byte;
            r_byte_valid <= |sel[6:2];
            r_begin      <= sel[2];
            r_end        <= sel[7] || (sel[6] && r_cmd.data_end);
            r_abort      <= sel[0];
            r_status     <= sel[1] ? r_cmd.status : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (adv) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_nal_begin  = r_begin;
    assign o_nal_end    = r_end;
    assign o_nal_abort  = r_abort;
    assign o_status     = r_status;

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_byte_valid |-> r_byte == 8'h00)
        else $error("marker result carries a nonzero byte");

    a_status_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_OK || r_abort) |-> !r_byte_valid && !r_end)
        else $error("status or abort on a data result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_byte))
        else $error("back end advanced while output stalled");

endmodule

>>> rtl/vvc_rtp_depacketizer.sv
// VVC RTP depacketiser top level: RTP payload bytes in, Annex-B stream out.
// Throughput: one payload byte per cycle in while the request queue has room, one
// result per cycle out while the sink is ready; a byte may cause up to 6 results,
// so the single output stage draining the request queue sets the sustained rate.
// Reset: synchronous active low; clears parser state, queue and output, and
// restores the fragment type to 29 and late drop to enabled.
module vvc_rtp_depacketizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // in_byte, seq_num
    input  logic                           s_axis_tuser,  // packet_first
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // out_byte
    output logic [4:0]                     m_axis_tuser,  // byte_valid, nal_begin,
                                                          // nal_abort, status
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [vrd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vrd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vrd_pkg::*;

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;
    logic byte_valid;
    logic nal_begin;
    logic nal_abort;
    logic [1:0] status;

    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && q_ready;

    vrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata[7:0]),
        .i_first    (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .i_seq      (s_axis_tdata[23:8]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    vrd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (pop)
    );

    vrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_byte_valid (byte_valid),
        .o_nal_begin  (nal_begin),
        .o_nal_end    (m_axis_tlast),
        .o_nal_abort  (nal_abort),
        .o_status     (status)
    );

    assign m_axis_tuser = {status, nal_abort, nal_begin, byte_valid};

endmodule

>>> bench/vvc_rtp_depacketizer_tb.sv
// Self-checking bench for the VVC RTP depacketiser: drives payload byte requests,
// predicts the Annex-B stream internally and checks every output result in order.
// Depends on rtl/vrd_pkg.sv and rtl/vvc_rtp_depacketizer.sv.
module vvc_rtp_depacketizer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vrd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SINK_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 10;

    typedef enum logic [1:0] {
        PM_IDLE = 2'd0,
        PM_NAL  = 2'd1,
        PM_FU   = 2'd2,
        PM_SKIP = 2'd3
    } t_pkt_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       nal_begin;
        logic       nal_end;
        logic       abort;
        t_status    status;
    } t_stream_res;

    typedef logic [7:0] t_payload[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_stream_res stream_q[$];
    int          n_bytes_sent  = 0;
    int          n_results     = 0;
    int          n_errors      = 0;
    int          stall_cycles  = 0;
    bit          gaps_on       = 1'b1;
    bit          sink_hold_req = 1'b0;

    logic [4:0]  cfg_fu_type = FU_TYPE_RESET;
    logic        cfg_late_en = 1'b1;

    logic [15:0] rx_last_seq = '0;
    logic        rx_seq_seen = 1'b0;
    logic [1:0]  rx_pos      = '0;
    logic [7:0]  rx_hdr0     = '0;
    logic [2:0]  rx_tid      = '0;
    t_pkt_mode   rx_mode     = PM_IDLE;
    logic        rx_nal_open = 1'b0;
    logic        rx_fu_end   = 1'b0;

    vvc_rtp_depacketizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void push_result(logic [7:0] d, logic v, logic b, logic e, logic a,
                                        t_status st);
        t_stream_res r;
        r.data      = d;
        r.valid     = v;
        r.nal_begin = b;
        r.nal_end   = e;
        r.abort     = a;
        r.status    = st;
        stream_q    = {stream_q, r};
    endfunction

    function automatic void push_start_code();
        push_result(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
        push_result(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
        push_result(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
    endfunction

    function automatic void depacketise(logic [7:0] b, logic first, logic last,
                                        logic [15:0] seq);
        logic [15:0] diff;
        logic        gap;
        logic        s, e, fin;
        if (first) begin
            if ((rx_mode == PM_NAL && rx_pos >= 2) || (rx_mode == PM_FU && rx_nal_open)) begin
                push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK);
                rx_nal_open = 1'b0;
            end
            rx_mode   = PM_IDLE;
            rx_pos    = 2'd0;
            rx_fu_end = 1'b0;
            diff      = seq - rx_last_seq;
            if (rx_seq_seen && cfg_late_en && diff[15]) begin
                push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_LATE);
                rx_mode = last ? PM_IDLE : PM_SKIP;
                return;
            end
            gap         = rx_seq_seen && diff >= 16'd2 && !diff[15];
            rx_last_seq = seq;
            rx_seq_seen = 1'b1;
            if (b[7:6] != 2'b00 || last) begin
                push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_MALF);
                rx_mode = last ? PM_IDLE : PM_SKIP;
                return;
            end
            if (gap)
                push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_GAP);
            rx_hdr0 = b;
            rx_mode = PM_NAL;
            rx_pos  = 2'd1;
            return;
        end

        case (rx_mode)
            PM_IDLE: return;
            PM_SKIP: begin
                if (last)
                    rx_mode = PM_IDLE;
                return;
            end
            PM_NAL: begin
                if (rx_pos <= 2'd1) begin
                    rx_tid = b[2:0];
                    if (b[7:3] == cfg_fu_type) begin
                        if (last) begin
                            push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_MALF);
                            rx_mode = PM_IDLE;
                        end else begin
                            rx_mode = PM_FU;
                            rx_pos  = 2'd2;
                        end
                        return;
                    end
                    if (rx_nal_open) begin
                        push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK);
                        rx_nal_open = 1'b0;
                    end
                    push_start_code();
                    push_result(rx_hdr0, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
                    push_result(b, 1'b1, 1'b0, last, 1'b0, ST_OK);
                    rx_pos = 2'd2;
                end else begin
                    push_result(b, 1'b1, 1'b0, last, 1'b0, ST_OK);
                    if (rx_pos != 2'd3)
                        rx_pos++;
                end
                if (last)
                    rx_mode = PM_IDLE;
            end
            PM_FU: begin
                if (rx_pos <= 2'd2) begin
                    s = b[7];
                    e = b[6];
                    if (s) begin
                        if (rx_nal_open)
                            push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK);
                        push_start_code();
                        push_result(rx_hdr0, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK);
                        push_result({b[4:0], rx_tid}, 1'b1, 1'b0, e && last, 1'b0, ST_OK);
                        rx_nal_open = !(e && last);
                    end else if (!rx_nal_open) begin
                        push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_MALF);
                        rx_mode = last ? PM_IDLE : PM_SKIP;
                        return;
                    end else if (e && last) begin
                        push_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
                        rx_nal_open = 1'b0;
                    end
                    rx_fu_end = e;
                    rx_pos    = 2'd3;
                end else if (rx_nal_open) begin
                    fin = last && rx_fu_end;
                    push_result(b, 1'b1, 1'b0, fin, 1'b0, ST_OK);
                    if (fin)
                        rx_nal_open = 1'b0;
                end
                if (last)
                    rx_mode = PM_IDLE;
            end
        endcase
    endfunction

    always @(negedge i_clk) begin : check_stream
        t_stream_res got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.data      = m_axis_tdata;
                got.valid     = m_axis_tuser[0];
                got.nal_begin = m_axis_tuser[1];
                got.nal_end   = m_axis_tlast;
                got.abort     = m_axis_tuser[2];
                got.status    = t_status'(m_axis_tuser[4:3]);
                n_results++;
                if (stream_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, got data=%02h valid=%b",
                             $time, got.data, got.valid);
                end else begin
                    want = stream_q.pop_front();
                    if (got != want) begin
                        n_errors++;
                        $display({"%0t: result %0d: expected data=%02h valid=%b begin=%b ",
                                  "end=%b abort=%b status=%0d, got data=%02h valid=%b ",
                                  "begin=%b end=%b abort=%b status=%0d"},
                                 $time, n_results, want.data, want.valid, want.nal_begin,
                                 want.nal_end, want.abort, want.status, got.data, got.valid,
                                 got.nal_begin, got.nal_end, got.abort, got.status);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin : sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                hold_left     = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!gaps_on) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 30);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] seq);
        bit took;
        if (gaps_on && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {seq, b};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        depacketise(b, first, last, seq);
        n_bytes_sent++;
    endtask

    task automatic send_packet(input logic [15:0] seq, input t_payload bytes, input bit closed);
        for (int j = 0; j < bytes.size(); j++)
            send_byte(bytes[j], j == 0, closed && j == bytes.size() - 1,
                      j == 0 ? seq : 16'($urandom));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (stream_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] fu_type, input logic late_en);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FU_TYPE;
        i_cfg_data <= CFG_DATA_W'(fu_type);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LATE_EN;
        i_cfg_data <= CFG_DATA_W'(late_en);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_fu_type = fu_type;
        cfg_late_en = late_en;
    endtask

    function automatic logic [15:0] pick_seq();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return rx_last_seq + 16'd1;
        if (r < 88)
            return rx_last_seq + 16'($urandom_range(2, 16'h7FFF));
        if (r < 96)
            return rx_last_seq - 16'($urandom_range(1, 16'h8000));
        return rx_last_seq;
    endfunction

    task automatic test_single_nal_cases();
        send_byte(8'hFF, 1'b0, 1'b0, 16'hFFFF);
        send_packet(16'hFFFF, '{8'h00, 8'h08, 8'hFF}, 1'b0);
        send_packet(16'h0000, '{8'h00}, 1'b1);
        send_packet(16'h0001, '{8'hC0, 8'h00}, 1'b1);
    endtask

    task automatic test_fragment_cases();
        send_packet(16'd2, '{8'h00, 8'hE9, 8'h85, 8'hAA}, 1'b1);
        send_packet(16'd2, '{8'h00, 8'hE9, 8'h45}, 1'b1);
        send_packet(16'd3, '{8'h00, 8'hE9, 8'h85}, 1'b1);
        send_packet(16'd4, '{8'h00, 8'h10}, 1'b1);
    endtask

    task automatic test_sequence_cases();
        send_packet(16'd3, '{8'h00, 8'h10}, 1'b1);
        send_packet(16'd5, '{8'h00, 8'hE9, 8'h05}, 1'b1);
        send_packet(16'd6, '{8'h00, 8'hE9}, 1'b1);
        send_packet(16'd9, '{8'h00, 8'hE9, 8'hC3}, 1'b1);
    endtask

    task automatic test_backpressure();
        t_payload pkt;
        gaps_on       = 1'b0;
        sink_hold_req = 1'b1;
        for (int p = 0; p < 6; p++) begin
            pkt = '{8'h00, 8'h08};
            repeat (6) pkt = {pkt, 8'($urandom)};
            send_packet(rx_last_seq + 16'd1, pkt, 1'b1);
        end
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(input logic [4:0] fu_type, input logic late_en,
                                       input int count, input bit idle);
        t_payload   pkt;
        int         target, k, nfrag;
        logic [7:0] hdr0;
        logic [2:0] tid;
        logic [4:0] ft;
        logic       s, e;
        wait_idle();
        set_config(fu_type, late_en);
        gaps_on = idle;
        target  = n_bytes_sent + count;
        while (n_bytes_sent < target) begin
            k    = $urandom_range(99);
            hdr0 = ($urandom_range(99) < 5) ? 8'($urandom) : {2'b00, 6'($urandom)};
            tid  = 3'($urandom);
            if (k < 45) begin
                ft    = 5'($urandom);
                nfrag = $urandom_range(1, 3);
                for (int f = 0; f < nfrag; f++) begin
                    s = (f == 0) ^ ($urandom_range(99) < 8);
                    e = (f == nfrag - 1) ^ ($urandom_range(99) < 8);
                    pkt = '{hdr0, {cfg_fu_type, tid}, {s, e, 1'($urandom), ft}};
                    repeat ($urandom_range(0, 4)) pkt = {pkt, 8'($urandom)};
                    send_packet(pick_seq(), pkt, $urandom_range(99) >= 5);
                end
            end else if (k < 75) begin
                pkt = '{hdr0, {5'($urandom), tid}};
                repeat ($urandom_range(0, 5)) pkt = {pkt, 8'($urandom)};
                send_packet(pick_seq(), pkt, $urandom_range(99) >= 5);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), $urandom_range(99) < 25, $urandom_range(99) < 30,
                              16'($urandom));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin : run
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_nal_cases();
        test_fragment_cases();
        test_sequence_cases();
        test_backpressure();
        test_random_traffic(5'd0, 1'b1, 65, 1'b1);
        test_random_traffic(5'd31, 1'b0, 65, 1'b0);
        test_random_traffic(FU_TYPE_RESET, 1'b1, 65, 1'b1);

        s_axis_tvalid <= 1'b0;
        while (stream_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d payload bytes and %0d checked stream results, %0d errors.",
                 n_bytes_sent, n_results, n_errors);
        $display("Fragment types 0, 29 and 31, late drop on and off, and a long output stall.");
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
rtl/vrd_pkg.sv
rtl/vrd_front.sv
rtl/vrd_cmd_fifo.sv
rtl/vrd_back.sv
rtl/vvc_rtp_depacketizer.sv
bench/vvc_rtp_depacketizer_tb.sv
